// ===== rtl/lavm_pkg.sv =====
// ---------------------------------------------------------------------------
// lavm_pkg
// Shared types, row codes and fixed-point helpers of the view matrix unit.
// ---------------------------------------------------------------------------
package lavm_pkg;

   typedef logic signed [31:0] fix_type;
   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      fix_type eye_x;
      fix_type eye_y;
      fix_type eye_z;
      fix_type target_x;
      fix_type target_y;
      fix_type target_z;
      fix_type upward_x;
      fix_type upward_y;
      fix_type upward_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      fix_type    col0;
      fix_type    col1;
      fix_type    col2;
      fix_type    col3;
      logic       last_row;
      logic       degenerate;
   } rsp_type;

   localparam logic [1:0] ROW_SIDE = 2'd0;
   localparam logic [1:0] ROW_UP   = 2'd1;
   localparam logic [1:0] ROW_BACK = 2'd2;
   localparam logic [1:0] ROW_LAST = 2'd3;

   // one root bit per stage for a 64-bit radicand
   localparam int ISQRT_STAGES = 32;
   // fixed part of the normalise pipeline depth, added to the divider stages
   localparam int NORM_FIXED_LAT = ISQRT_STAGES + 8;

   function automatic wide_type smul(fix_type a, fix_type b);
      return 64'(a) * 64'(b);
   endfunction

   // scale down by 2^frac, round to nearest, ties away from zero
   function automatic wide_type round_shift(wide_type v, int frac);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'(1) << (frac - 1))) >> frac;
      return v[63] ? -wide_type'(mag) : wide_type'(mag);
   endfunction

   function automatic fix_type sat_fix(wide_type v);
      if (v > 64'sh0000_0000_7fff_ffff) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/look_at_view_matrix_unit.sv =====
// ---------------------------------------------------------------------------
// look_at_view_matrix_unit
// Camera view matrix from eye, target and up vector in signed fixed point.
// ---------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   start, busy, req_data       taken when start is high, busy low
//  result    rsp_valid, rsp_data         one row per cycle, four per item
//
//  after each accepted item busy stays high and counts down before the next
//  item is taken, as the four rows share the single result port.
//  an item passes the two normalise pipelines (square root and divider
//  stages) and the cross and translation stages before its first row appears.
//  the receiver cannot stall, so the pipeline never holds; reset is
//  synchronous and clears all valid bits and the row sequencer.
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lavm_pkg::req_type req_data,
   output logic              rsp_valid,
   output lavm_pkg::rsp_type rsp_data
);
   import lavm_pkg::*;

   localparam int NORM_LAT = FRAC_BITS + 1 + NORM_FIXED_LAT;
   localparam fix_type ONE_FIX = fix_type'(32'(1) << FRAC_BITS);

   // input throttle
   logic [1:0] gap_ff;
   logic       accept;

   assign busy   = (gap_ff != 2'd0);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
      end else if (accept) begin
         gap_ff <= 2'd3;
      end else if (busy) begin
         gap_ff <= gap_ff - 2'd1;
      end
   end

   // valid chain
   logic a_valid_ff, b_valid_ff, x1_valid_ff, x2_valid_ff;
   logic u1_valid_ff, u2_valid_ff, u3_valid_ff;
   logic d1_valid_ff, d2_valid_ff, d3_valid_ff, d4_valid_ff;
   logic n1_valid, n2_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         x1_valid_ff <= 1'b0;
         x2_valid_ff <= 1'b0;
         u1_valid_ff <= 1'b0;
         u2_valid_ff <= 1'b0;
         u3_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
         d4_valid_ff <= 1'b0;
      end else begin
         a_valid_ff  <= accept;
         b_valid_ff  <= a_valid_ff;
         x1_valid_ff <= n1_valid;
         x2_valid_ff <= x1_valid_ff;
         u1_valid_ff <= n2_valid;
         u2_valid_ff <= u1_valid_ff;
         u3_valid_ff <= u2_valid_ff;
         d1_valid_ff <= u3_valid_ff;
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
         d4_valid_ff <= d3_valid_ff;
      end
   end

   // input register and difference
   req_type  a_req_ff;
   wide_type b_d_ff [3];
   fix_type  b_eye_ff [3];
   fix_type  b_up_ff [3];

   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      b_d_ff[0]   <= 64'(a_req_ff.target_x) - 64'(a_req_ff.eye_x);
      b_d_ff[1]   <= 64'(a_req_ff.target_y) - 64'(a_req_ff.eye_y);
      b_d_ff[2]   <= 64'(a_req_ff.target_z) - 64'(a_req_ff.eye_z);
      b_eye_ff[0] <= a_req_ff.eye_x;
      b_eye_ff[1] <= a_req_ff.eye_y;
      b_eye_ff[2] <= a_req_ff.eye_z;
      b_up_ff[0]  <= a_req_ff.upward_x;
      b_up_ff[1]  <= a_req_ff.upward_y;
      b_up_ff[2]  <= a_req_ff.upward_z;
   end

   // forward axis
   fix_type      n1_f [3];
   logic         n1_zero;
   logic [191:0] side1;
   fix_type      n1_eye [3];
   fix_type      n1_up [3];

   lavm_norm #(
      .FRAC_BITS (FRAC_BITS)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_vec    (b_d_ff),
      .out_valid (n1_valid),
      .out_vec   (n1_f),
      .out_zero  (n1_zero)
   );

   lavm_delay #(
      .WIDTH (192),
      .DEPTH (NORM_LAT)
   ) u_side_fwd (
      .clock    (clock),
      .in_data  ({b_eye_ff[0], b_eye_ff[1], b_eye_ff[2],
                  b_up_ff[0], b_up_ff[1], b_up_ff[2]}),
      .out_data (side1)
   );

   assign n1_eye[0] = side1[191:160];
   assign n1_eye[1] = side1[159:128];
   assign n1_eye[2] = side1[127:96];
   assign n1_up[0]  = side1[95:64];
   assign n1_up[1]  = side1[63:32];
   assign n1_up[2]  = side1[31:0];

   // forward cross up
   wide_type x1_pr_ff [6];
   fix_type  x1_f_ff [3];
   fix_type  x1_eye_ff [3];
   logic     x1_zero_ff;
   wide_type x2_c_ff [3];
   fix_type  x2_f_ff [3];
   fix_type  x2_eye_ff [3];
   logic     x2_zero_ff;

   always_ff @(posedge clock) begin
      x1_pr_ff[0] <= smul(n1_f[1], n1_up[2]);
      x1_pr_ff[1] <= smul(n1_f[2], n1_up[1]);
      x1_pr_ff[2] <= smul(n1_f[2], n1_up[0]);
      x1_pr_ff[3] <= smul(n1_f[0], n1_up[2]);
      x1_pr_ff[4] <= smul(n1_f[0], n1_up[1]);
      x1_pr_ff[5] <= smul(n1_f[1], n1_up[0]);
      x1_f_ff     <= n1_f;
      x1_eye_ff   <= n1_eye;
      x1_zero_ff  <= n1_zero;
      x2_c_ff[0]  <= x1_pr_ff[0] - x1_pr_ff[1];
      x2_c_ff[1]  <= x1_pr_ff[2] - x1_pr_ff[3];
      x2_c_ff[2]  <= x1_pr_ff[4] - x1_pr_ff[5];
      x2_f_ff     <= x1_f_ff;
      x2_eye_ff   <= x1_eye_ff;
      x2_zero_ff  <= x1_zero_ff;
   end

   // side axis
   fix_type      n2_s [3];
   logic         n2_zero;
   logic [192:0] side2;
   fix_type      n2_f [3];
   fix_type      n2_eye [3];
   logic         n2_zero_fwd;

   lavm_norm #(
      .FRAC_BITS (FRAC_BITS)
   ) u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x2_valid_ff),
      .in_vec    (x2_c_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_s),
      .out_zero  (n2_zero)
   );

   lavm_delay #(
      .WIDTH (193),
      .DEPTH (NORM_LAT)
   ) u_side_side (
      .clock    (clock),
      .in_data  ({x2_f_ff[0], x2_f_ff[1], x2_f_ff[2],
                  x2_eye_ff[0], x2_eye_ff[1], x2_eye_ff[2], x2_zero_ff}),
      .out_data (side2)
   );

   assign n2_f[0]     = side2[192:161];
   assign n2_f[1]     = side2[160:129];
   assign n2_f[2]     = side2[128:97];
   assign n2_eye[0]   = side2[96:65];
   assign n2_eye[1]   = side2[64:33];
   assign n2_eye[2]   = side2[32:1];
   assign n2_zero_fwd = side2[0];

   // true up = side cross forward
   wide_type u1_pr_ff [6];
   fix_type  u1_s_ff [3];
   fix_type  u1_f_ff [3];
   fix_type  u1_eye_ff [3];
   logic     u1_degen_ff;
   wide_type u2_c_ff [3];
   fix_type  u2_s_ff [3];
   fix_type  u2_f_ff [3];
   fix_type  u2_eye_ff [3];
   logic     u2_degen_ff;
   fix_type  u3_s_ff [3];
   fix_type  u3_u_ff [3];
   fix_type  u3_f_ff [3];
   fix_type  u3_eye_ff [3];
   logic     u3_degen_ff;

   always_ff @(posedge clock) begin
      u1_pr_ff[0] <= smul(n2_s[1], n2_f[2]);
      u1_pr_ff[1] <= smul(n2_s[2], n2_f[1]);
      u1_pr_ff[2] <= smul(n2_s[2], n2_f[0]);
      u1_pr_ff[3] <= smul(n2_s[0], n2_f[2]);
      u1_pr_ff[4] <= smul(n2_s[0], n2_f[1]);
      u1_pr_ff[5] <= smul(n2_s[1], n2_f[0]);
      u1_s_ff     <= n2_s;
      u1_f_ff     <= n2_f;
      u1_eye_ff   <= n2_eye;
      u1_degen_ff <= n2_zero || n2_zero_fwd;
      u2_c_ff[0]  <= u1_pr_ff[0] - u1_pr_ff[1];
      u2_c_ff[1]  <= u1_pr_ff[2] - u1_pr_ff[3];
      u2_c_ff[2]  <= u1_pr_ff[4] - u1_pr_ff[5];
      u2_s_ff     <= u1_s_ff;
      u2_f_ff     <= u1_f_ff;
      u2_eye_ff   <= u1_eye_ff;
      u2_degen_ff <= u1_degen_ff;
      for (int i = 0; i < 3; i++) begin
         u3_u_ff[i] <= fix_type'(32'(round_shift(u2_c_ff[i], FRAC_BITS)));
      end
      u3_s_ff     <= u2_s_ff;
      u3_f_ff     <= u2_f_ff;
      u3_eye_ff   <= u2_eye_ff;
      u3_degen_ff <= u2_degen_ff;
   end

   // translation terms: minus axis dot eye
   fix_type  d1_ax_ff [3][3];
   wide_type d1_pr_ff [3][3];
   logic     d1_degen_ff;
   fix_type  d2_ax_ff [3][3];
   wide_type d2_dot_ff [3];
   logic     d2_degen_ff;
   fix_type  d3_ax_ff [3][3];
   wide_type d3_rs_ff [3];
   logic     d3_degen_ff;
   fix_type  d4_ax_ff [3][3];
   fix_type  d4_tr_ff [3];
   logic     d4_degen_ff;
   fix_type  ax_in [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax_in[0][i] = u3_s_ff[i];
         ax_in[1][i] = u3_u_ff[i];
         ax_in[2][i] = -u3_f_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int i = 0; i < 3; i++) begin
            d1_pr_ff[r][i] <= smul(ax_in[r][i], u3_eye_ff[i]);
         end
         d2_dot_ff[r] <= d1_pr_ff[r][0] + d1_pr_ff[r][1] + d1_pr_ff[r][2];
         d3_rs_ff[r]  <= round_shift(d2_dot_ff[r], FRAC_BITS);
         d4_tr_ff[r]  <= sat_fix(-d3_rs_ff[r]);
      end
      d1_ax_ff    <= ax_in;
      d1_degen_ff <= u3_degen_ff;
      d2_ax_ff    <= d1_ax_ff;
      d2_degen_ff <= d1_degen_ff;
      d3_ax_ff    <= d2_ax_ff;
      d3_degen_ff <= d2_degen_ff;
      d4_ax_ff    <= d3_ax_ff;
      d4_degen_ff <= d3_degen_ff;
   end

   // row sequencer: holds one item's rows and sends one per cycle
   fix_type    hold_ax_ff [3][3];
   fix_type    hold_tr_ff [3];
   logic       hold_degen_ff;
   logic       emit_ff;
   logic [1:0] row_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    row_in;

   always_ff @(posedge clock) begin
      if (d4_valid_ff) begin
         hold_ax_ff    <= d4_ax_ff;
         hold_tr_ff    <= d4_tr_ff;
         hold_degen_ff <= d4_degen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff      <= 1'b0;
         row_ff       <= ROW_SIDE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_ff;
         if (d4_valid_ff) begin
            emit_ff <= 1'b1;
            row_ff  <= ROW_SIDE;
         end else if (emit_ff) begin
            if (row_ff == ROW_LAST) begin
               emit_ff <= 1'b0;
            end
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_comb begin
      row_in            = '0;
      row_in.row_index  = row_ff;
      row_in.degenerate = hold_degen_ff;
      case (row_ff)
         ROW_SIDE, ROW_UP, ROW_BACK: begin
            if (!hold_degen_ff) begin
               row_in.col0 = hold_ax_ff[row_ff][0];
               row_in.col1 = hold_ax_ff[row_ff][1];
               row_in.col2 = hold_ax_ff[row_ff][2];
               row_in.col3 = hold_tr_ff[row_ff];
            end
         end
         default: begin
            row_in.col3     = ONE_FIX;
            row_in.last_row = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= row_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/lavm_delay.sv =====
// ---------------------------------------------------------------------------
// lavm_delay
// Fixed-length shift line that keeps side data in step with a pipeline.
// ---------------------------------------------------------------------------
module lavm_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule

// ===== rtl/lavm_isqrt.sv =====
// ---------------------------------------------------------------------------
// lavm_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ---------------------------------------------------------------------------
module lavm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_radicand,
   output logic        out_valid,
   output logic [31:0] out_root
);
   import lavm_pkg::*;

   logic        v_ff    [ISQRT_STAGES];
   logic [33:0] rem_ff  [ISQRT_STAGES];
   logic [31:0] root_ff [ISQRT_STAGES];
   logic [63:0] rad_ff  [ISQRT_STAGES];
   logic [33:0] rem_in  [ISQRT_STAGES];
   logic [31:0] root_in [ISQRT_STAGES];
   logic [63:0] rad_in  [ISQRT_STAGES];

   always_comb begin
      logic [33:0] p_rem;
      logic [31:0] p_root;
      logic [63:0] p_rad;
      logic [35:0] trial;
      logic [35:0] test;
      for (int j = 0; j < ISQRT_STAGES; j++) begin
         if (j == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rad  = in_radicand;
         end else begin
            p_rem  = rem_ff[j-1];
            p_root = root_ff[j-1];
            p_rad  = rad_ff[j-1];
         end
         trial = {p_rem, p_rad[63:62]};
         test  = {2'b00, p_root, 2'b01};
         if (trial >= test) begin
            rem_in[j]  = 34'(trial - test);
            root_in[j] = {p_root[30:0], 1'b1};
         end else begin
            rem_in[j]  = trial[33:0];
            root_in[j] = {p_root[30:0], 1'b0};
         end
         rad_in[j] = p_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ISQRT_STAGES; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int j = 1; j < ISQRT_STAGES; j++) begin
            v_ff[j] <= v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ISQRT_STAGES; j++) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         rad_ff[j]  <= rad_in[j];
      end
   end

   assign out_valid = v_ff[ISQRT_STAGES-1];
   assign out_root  = root_ff[ISQRT_STAGES-1];

endmodule

// ===== rtl/lavm_norm.sv =====
// ---------------------------------------------------------------------------
// lavm_norm
// Pipelined vector normalise: range scaling, sum of squares, square root
// and three restoring dividers giving unit components in fixed point.
// ---------------------------------------------------------------------------
module lavm_norm #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lavm_pkg::wide_type in_vec [3],
   output logic              out_valid,
   output lavm_pkg::fix_type out_vec [3],
   output logic              out_zero
);
   import lavm_pkg::*;

   localparam int QBITS = FRAC_BITS + 1;
   localparam int NUM_W = FRAC_BITS + 32;
   localparam int SIDE_W = 3 * 31 + 4;

   // stage 1: magnitudes and largest
   logic [63:0] mag_in [3];
   logic [2:0]  neg_in;
   logic [63:0] big_in;
   logic        s1_valid_ff;
   logic [63:0] s1_mag_ff [3];
   logic [2:0]  s1_neg_ff;
   logic [63:0] s1_big_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_vec[i][63];
         mag_in[i] = neg_in[i] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
      end
      big_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      if (mag_in[2] > big_in) begin
         big_in = mag_in[2];
      end
   end

   // stage 2: leading one within each 16-bit group
   logic [3:0]  grp_nz_in;
   logic [3:0]  grp_pos_in [4];
   logic        s2_valid_ff;
   logic [63:0] s2_mag_ff [3];
   logic [2:0]  s2_neg_ff;
   logic [3:0]  s2_nz_ff;
   logic [3:0]  s2_pos_ff [4];

   always_comb begin
      for (int g = 0; g < 4; g++) begin
         grp_nz_in[g]  = |s1_big_ff[16*g +: 16];
         grp_pos_in[g] = '0;
         for (int b = 0; b < 16; b++) begin
            if (s1_big_ff[16*g + b]) begin
               grp_pos_in[g] = 4'(b);
            end
         end
      end
   end

   // stage 3: leading one of the whole word
   logic [5:0]  msb_in;
   logic        s3_valid_ff;
   logic [63:0] s3_mag_ff [3];
   logic [2:0]  s3_neg_ff;
   logic [5:0]  s3_msb_ff;
   logic        s3_zero_ff;

   always_comb begin
      msb_in = '0;
      for (int g = 0; g < 4; g++) begin
         if (s2_nz_ff[g]) begin
            msb_in = {2'(g), s2_pos_ff[g]};
         end
      end
   end

   // stage 4: shift so the largest magnitude has its top bit at bit 30
   logic [30:0] m_in [3];
   logic        s4_valid_ff;
   logic [30:0] s4_m_ff [3];
   logic [2:0]  s4_neg_ff;
   logic        s4_zero_ff;

   always_comb begin
      logic [63:0] sh;
      for (int i = 0; i < 3; i++) begin
         if (s3_msb_ff >= 6'd30) begin
            sh = s3_mag_ff[i] >> (s3_msb_ff - 6'd30);
         end else begin
            sh = s3_mag_ff[i] << (6'd30 - s3_msb_ff);
         end
         m_in[i] = sh[30:0];
      end
   end

   // stages 5 and 6: squares, then their sum
   logic        s5_valid_ff;
   logic [61:0] s5_sq_ff [3];
   logic [30:0] s5_m_ff [3];
   logic [2:0]  s5_neg_ff;
   logic        s5_zero_ff;
   logic        s6_valid_ff;
   logic [63:0] s6_sum_ff;
   logic [30:0] s6_m_ff [3];
   logic [2:0]  s6_neg_ff;
   logic        s6_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_mag_ff  <= mag_in;
      s1_neg_ff  <= neg_in;
      s1_big_ff  <= big_in;
      s2_mag_ff  <= s1_mag_ff;
      s2_neg_ff  <= s1_neg_ff;
      s2_nz_ff   <= grp_nz_in;
      s2_pos_ff  <= grp_pos_in;
      s3_mag_ff  <= s2_mag_ff;
      s3_neg_ff  <= s2_neg_ff;
      s3_msb_ff  <= msb_in;
      s3_zero_ff <= ~|s2_nz_ff;
      s4_m_ff    <= m_in;
      s4_neg_ff  <= s3_neg_ff;
      s4_zero_ff <= s3_zero_ff;
      for (int i = 0; i < 3; i++) begin
         s5_sq_ff[i] <= 62'(s4_m_ff[i]) * 62'(s4_m_ff[i]);
      end
      s5_m_ff    <= s4_m_ff;
      s5_neg_ff  <= s4_neg_ff;
      s5_zero_ff <= s4_zero_ff;
      s6_sum_ff  <= 64'(s5_sq_ff[0]) + 64'(s5_sq_ff[1]) + 64'(s5_sq_ff[2]);
      s6_m_ff    <= s5_m_ff;
      s6_neg_ff  <= s5_neg_ff;
      s6_zero_ff <= s5_zero_ff;
   end

   // square root with the scaled magnitudes alongside
   logic              root_valid;
   logic [31:0]       root;
   logic [SIDE_W-1:0] side_d;
   logic [30:0]       sd_m [3];
   logic [2:0]        sd_neg;
   logic              sd_zero;

   lavm_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s6_valid_ff),
      .in_radicand (s6_sum_ff),
      .out_valid   (root_valid),
      .out_root    (root)
   );

   lavm_delay #(
      .WIDTH (SIDE_W),
      .DEPTH (ISQRT_STAGES)
   ) u_side (
      .clock    (clock),
      .in_data  ({s6_m_ff[0], s6_m_ff[1], s6_m_ff[2], s6_neg_ff, s6_zero_ff}),
      .out_data (side_d)
   );

   assign sd_m[0] = side_d[96:66];
   assign sd_m[1] = side_d[65:35];
   assign sd_m[2] = side_d[34:4];
   assign sd_neg  = side_d[3:1];
   assign sd_zero = side_d[0];

   // divider stages: index 0 is loaded from the rounded numerator
   logic             dv_ff   [QBITS+1];
   logic [31:0]      drem_ff [QBITS+1][3];
   logic [QBITS-1:0] dlow_ff [QBITS+1][3];
   logic [QBITS-1:0] dq_ff   [QBITS+1][3];
   logic [31:0]      dlen_ff [QBITS+1];
   logic [2:0]       dneg_ff [QBITS+1];
   logic             dzero_ff[QBITS+1];
   logic [31:0]      rem0_in [3];
   logic [QBITS-1:0] low0_in [3];
   logic [31:0]      drem_in [QBITS][3];
   logic [QBITS-1:0] dlow_in [QBITS][3];
   logic [QBITS-1:0] dq_in   [QBITS][3];

   always_comb begin
      logic [NUM_W-1:0] num;
      for (int i = 0; i < 3; i++) begin
         num        = (NUM_W'(sd_m[i]) << FRAC_BITS) + NUM_W'(root >> 1);
         rem0_in[i] = {1'b0, num[NUM_W-1:QBITS]};
         low0_in[i] = num[QBITS-1:0];
      end
   end

   always_comb begin
      logic [32:0] trial;
      for (int j = 0; j < QBITS; j++) begin
         for (int i = 0; i < 3; i++) begin
            trial = {drem_ff[j][i], dlow_ff[j][i][QBITS-1]};
            if (trial >= {1'b0, dlen_ff[j]}) begin
               drem_in[j][i] = 32'(trial - {1'b0, dlen_ff[j]});
               dq_in[j][i]   = {dq_ff[j][i][QBITS-2:0], 1'b1};
            end else begin
               drem_in[j][i] = trial[31:0];
               dq_in[j][i]   = {dq_ff[j][i][QBITS-2:0], 1'b0};
            end
            dlow_in[j][i] = dlow_ff[j][i] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QBITS; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= root_valid;
         for (int j = 0; j < QBITS; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      drem_ff[0]  <= rem0_in;
      dlow_ff[0]  <= low0_in;
      for (int i = 0; i < 3; i++) begin
         dq_ff[0][i] <= '0;
      end
      dlen_ff[0]  <= root;
      dneg_ff[0]  <= sd_neg;
      dzero_ff[0] <= sd_zero;
      for (int j = 0; j < QBITS; j++) begin
         drem_ff[j+1]  <= drem_in[j];
         dlow_ff[j+1]  <= dlow_in[j];
         dq_ff[j+1]    <= dq_in[j];
         dlen_ff[j+1]  <= dlen_ff[j];
         dneg_ff[j+1]  <= dneg_ff[j];
         dzero_ff[j+1] <= dzero_ff[j];
      end
   end

   // sign restore and zero-length masking
   logic    out_valid_ff;
   fix_type out_vec_ff [3];
   logic    out_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (dzero_ff[QBITS]) begin
            out_vec_ff[i] <= '0;
         end else if (dneg_ff[QBITS][i]) begin
            out_vec_ff[i] <= -fix_type'(32'(dq_ff[QBITS][i]));
         end else begin
            out_vec_ff[i] <= fix_type'(32'(dq_ff[QBITS][i]));
         end
      end
      out_zero_ff <= dzero_ff[QBITS];
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_zero  = out_zero_ff;

endmodule

// ===== rtl/lavm_check.sv =====
// ---------------------------------------------------------------------------
// lavm_check
// Port-level checks on item pacing and row sequencing of the view unit.
// ---------------------------------------------------------------------------
module lavm_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input lavm_pkg::rsp_type rsp_data
);
   import lavm_pkg::*;

   // busy stays high after an item is taken, holding the request side off
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy ##1 busy)
      else $error("busy not held after an item");

   // rows run side, up, back, last without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.row_index != ROW_LAST) |=>
         (rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1))
      else $error("row sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_LAST)))
      else $error("last row flag wrong");

   // degenerate flag is the same on every row of an item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_row) |=>
         (rsp_data.degenerate == $past(rsp_data.degenerate)))
      else $error("degenerate flag changed within an item");

endmodule

bind look_at_view_matrix_unit lavm_check u_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Checks the view matrix unit against an in-bench predictor of its four rows.
// Directed cameras (extremes, degenerate looks, saturating translations) are
// followed by random items sent in bursts; every row is compared per field.
// ---------------------------------------------------------------------------
module tb_top;

   import lavm_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam int N_RANDOM   = 430;
   localparam int DRAIN      = 2 * FRAC_BITS + 160;

   class view_scoreboard;
      rsp_type pending_rows[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      function automatic logic [63:0] mag_of(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function automatic longint round_frac(longint v);
         logic [63:0] m;
         m = mag_of(v);
         m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return v < 0 ? -longint'(m) : longint'(m);
      endfunction

      function automatic logic [63:0] floor_root(logic [63:0] x);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // zero vector gives 0 and a zero result
      function automatic bit unit_vec(input longint v[3], output longint o[3]);
         logic [63:0] m[3];
         logic [63:0] big, sum, len, q;
         big = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = mag_of(v[i]);
            if (m[i] > big) big = m[i];
            o[i] = 0;
         end
         if (big == 0) return 0;
         while (big >= (64'd1 << 31)) begin
            big = big >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         end
         while (big < (64'd1 << 30)) begin
            big = big << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         end
         for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
         len = floor_root(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
         return 1;
      endfunction

      function automatic fix_type clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fff_ffff;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function void note_item(req_type it);
         longint eye[3], tgt[3], upv[3], d[3], f[3], c[3], s[3], u[3];
         longint axis[3][3];
         longint dot;
         bit      degen;
         rsp_type row;
         eye = '{longint'(it.eye_x), longint'(it.eye_y), longint'(it.eye_z)};
         tgt = '{longint'(it.target_x), longint'(it.target_y), longint'(it.target_z)};
         upv = '{longint'(it.upward_x), longint'(it.upward_y), longint'(it.upward_z)};
         for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
         degen = !unit_vec(d, f);
         c[0] = f[1] * upv[2] - f[2] * upv[1];
         c[1] = f[2] * upv[0] - f[0] * upv[2];
         c[2] = f[0] * upv[1] - f[1] * upv[0];
         if (!unit_vec(c, s)) degen = 1;
         u[0] = round_frac(s[1] * f[2] - s[2] * f[1]);
         u[1] = round_frac(s[2] * f[0] - s[0] * f[2]);
         u[2] = round_frac(s[0] * f[1] - s[1] * f[0]);
         for (int i = 0; i < 3; i++) begin
            axis[0][i] = s[i];
            axis[1][i] = u[i];
            axis[2][i] = -f[i];
         end
         for (int r = 0; r < 3; r++) begin
            dot = axis[r][0] * eye[0] + axis[r][1] * eye[1] + axis[r][2] * eye[2];
            row.row_index  = 2'(r);
            row.col0       = degen ? '0 : axis[r][0][31:0];
            row.col1       = degen ? '0 : axis[r][1][31:0];
            row.col2       = degen ? '0 : axis[r][2][31:0];
            row.col3       = degen ? '0 : clamp32(-round_frac(dot));
            row.last_row   = 1'b0;
            row.degenerate = degen;
            pending_rows.push_back(row);
         end
         row.row_index  = ROW_LAST;
         row.col0       = '0;
         row.col1       = '0;
         row.col2       = '0;
         row.col3       = 32'sd1 <<< FRAC_BITS;
         row.last_row   = 1'b1;
         row.degenerate = degen;
         pending_rows.push_back(row);
      endfunction

      function void check_row(rsp_type got);
         rsp_type want;
         if (pending_rows.size() == 0) begin
            $error("row %0d with no item outstanding", got.row_index);
            errors++;
            return;
         end
         want = pending_rows.pop_front();
         if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            errors++;
         end
         if (got.col0 !== want.col0) begin
            $error("col0: expected %h, got %h", want.col0, got.col0);
            errors++;
         end
         if (got.col1 !== want.col1) begin
            $error("col1: expected %h, got %h", want.col1, got.col1);
            errors++;
         end
         if (got.col2 !== want.col2) begin
            $error("col2: expected %h, got %h", want.col2, got.col2);
            errors++;
         end
         if (got.col3 !== want.col3) begin
            $error("col3: expected %h, got %h", want.col3, got.col3);
            errors++;
         end
         if (got.last_row !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
            errors++;
         end
         if (got.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   view_scoreboard rows_sb;
   int idle_cycles;
   int burst_left;

   look_at_view_matrix_unit #(.FRAC_BITS(FRAC_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) rows_sb.check_row(rsp_data);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      idle_cycles = 0;
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // item held until taken; bursts of items with random gaps between them
   task automatic send_item(input req_type it);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
      end
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      rows_sb.note_item(it);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic fix_type near_fix();
      return fix_type'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
   endfunction

   function automatic req_type make_item(fix_type ex, fix_type ey, fix_type ez,
                                         fix_type tx, fix_type ty, fix_type tz,
                                         fix_type ux, fix_type uy, fix_type uz);
      req_type it;
      it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int      mode;
      fix_type k;
      mode = $urandom_range(0, 9);
      it.eye_x = near_fix(); it.eye_y = near_fix(); it.eye_z = near_fix();
      it.target_x = near_fix(); it.target_y = near_fix(); it.target_z = near_fix();
      it.upward_x = near_fix(); it.upward_y = near_fix(); it.upward_z = near_fix();
      case (mode)
         0, 1: begin
            it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
         end
         7: begin
            // up along the view direction
            k = fix_type'($urandom_range(1, 3));
            it.upward_x = (it.target_x - it.eye_x) * k;
            it.upward_y = (it.target_y - it.eye_y) * k;
            it.upward_z = (it.target_z - it.eye_z) * k;
         end
         8: begin
            it.target_x = it.eye_x; it.target_y = it.eye_y; it.target_z = it.eye_z;
         end
         9: begin
            // far eye, translation near or past the 32-bit range
            it.eye_x = fix_type'($urandom) | 32'sh4000_0000;
            it.eye_y = fix_type'($urandom);
            it.eye_z = -fix_type'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
            it.target_x = it.eye_x + near_fix();
            it.target_y = it.eye_y + near_fix();
            it.target_z = it.eye_z + near_fix();
         end
         default: ;
      endcase
      return it;
   endfunction

   localparam fix_type ONE  = 32'sh0001_0000;
   localparam fix_type PMAX = 32'sh7fff_ffff;
   localparam fix_type NMAX = 32'sh8000_0000;

   initial begin
      rows_sb    = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(make_item(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
      send_item(make_item(ONE, 2*ONE, 5*ONE, 0, 0, 0, 0, ONE, 0));
      send_item(make_item(PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX, PMAX));
      send_item(make_item(NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, NMAX, PMAX, NMAX));
      send_item(make_item(PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, NMAX, NMAX));
      send_item(make_item(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0, ONE, 0));
      send_item(make_item(NMAX, 0, 0, NMAX, 0, 0, ONE, 0, 0));
      send_item(make_item(0, 0, 0, 0, ONE, 0, 0, ONE, 0));
      send_item(make_item(0, 0, 0, 0, 0, ONE, 0, 0, 0));
      send_item(make_item(3*ONE, 0, 0, 0, 0, 0, -2*ONE, 0, 0));
      send_item(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_item(make_item(0, 0, 0, 1, 1, 1, -1, -1, -1));
      send_item(make_item(PMAX, PMAX, PMAX, PMAX - ONE, PMAX, PMAX, 0, ONE, 0));
      send_item(make_item(NMAX, NMAX, NMAX, NMAX + ONE, NMAX, NMAX, 0, 0, ONE));
      send_item(make_item(PMAX, NMAX, PMAX, PMAX, NMAX + ONE, PMAX, ONE, 0, ONE));
      send_item(make_item(-1, -1, -1, 0, 0, 0, PMAX, PMAX, NMAX));
      send_item(make_item(ONE, ONE, ONE, -ONE, ONE, -ONE, 0, ONE, 0));
      for (int n = 0; n < N_RANDOM; n++) send_item(random_item());
      start <= 1'b0;

      while (rows_sb.pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (rows_sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
